/* hw/rtl/mlfd_pkg.sv */
// Package for the marker / length frame deframer.
// Holds the phase and result codes, the result struct, size constants and the marker table.
// No dependencies.
`timescale 1ns / 1ps

package mlfd_pkg;

	localparam int BUFFER_BYTES = 65536;
	localparam int LEN_W = 16;
	localparam int POS_W = 16;
	localparam int MARKER_LEN = 7;
	localparam int LENGTH_LEN = 4;
	localparam int TRAILER_LEN = 5;

	// Payload cap that lets the whole frame fit the buffer with a byte to spare.
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(BUFFER_BYTES - 17);
	localparam logic [LEN_W-1:0] LEN_RESET = 16'd65519;
	localparam logic [7:0] MARKER_FIRST = 8'h59;

	typedef enum logic [1:0] {
		PH_MARKER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_TRAILER = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD    = 2'd0,
		KIND_DONE       = 2'd1,
		KIND_MARKER_ERR = 2'd2,
		KIND_LEN_ERR    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       last_payload;
	} result_t;

	// Bytes of the start marker "YFSTART".
	function automatic logic [7:0] marker_byte(input logic [2:0] idx);
		logic [7:0] b;
		b = MARKER_FIRST;
		case (idx)
			3'd0: b = 8'h59;
			3'd1: b = 8'h46;
			3'd2: b = 8'h53;
			3'd3: b = 8'h54;
			3'd4: b = 8'h41;
			3'd5: b = 8'h52;
			3'd6: b = 8'h54;
			default: b = MARKER_FIRST;
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/mlfd_parse.sv */
// Frame parser: phase state machine, position and length counters, length limit register.
// Depends on mlfd_pkg.
`timescale 1ns / 1ps

module mlfd_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                step,
	input  logic [7:0]          byte_in,
	output logic                has_result,
	output mlfd_pkg::result_t   result
);
	import mlfd_pkg::*;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             len_hi_q, len_hi_d;
	logic [LEN_W-1:0] lim_q;
	logic [POS_W:0]   pos_inc;
	logic             big;

	assign pos_inc = {1'b0, pos_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LEN_RESET;
		end else if (cfg_we) begin
			// The buffer cap is applied once here instead of on every byte.
			lim_q <= (cfg_data > LEN_CAP) ? LEN_CAP : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MARKER;
			pos_q    <= '0;
			len_q    <= '0;
			len_hi_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			len_hi_q <= len_hi_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		len_d      = len_q;
		len_hi_d   = len_hi_q;
		has_result = 1'b0;
		result     = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, last_payload: 1'b0};
		big        = 1'b0;
		unique case (phase_q)
			PH_MARKER: begin
				if (byte_in != marker_byte(pos_q[2:0])) begin
					// A stray 'Y' may start the next marker.
					pos_d       = (byte_in == MARKER_FIRST) ? POS_W'(1) : '0;
					has_result  = 1'b1;
					result.kind = KIND_MARKER_ERR;
				end else if (pos_q == POS_W'(MARKER_LEN - 1)) begin
					phase_d  = PH_LENGTH;
					pos_d    = '0;
					len_d    = '0;
					len_hi_d = 1'b0;
				end else begin
					pos_d = pos_inc[POS_W-1:0];
				end
			end
			PH_LENGTH: begin
				unique case (pos_q[1:0])
					2'd0: len_d[7:0] = byte_in;
					2'd1: len_d[15:8] = byte_in;
					default: len_hi_d = len_hi_q | (byte_in != 8'h00);
				endcase
				pos_d = pos_inc[POS_W-1:0];
				if (pos_q == POS_W'(LENGTH_LEN - 1)) begin
					big   = len_hi_d | (len_q > lim_q);
					pos_d = '0;
					if (big) begin
						phase_d     = PH_MARKER;
						len_d       = '0;
						len_hi_d    = 1'b0;
						has_result  = 1'b1;
						result.kind = KIND_LEN_ERR;
					end else begin
						phase_d = (len_q == '0) ? PH_TRAILER : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				has_result          = 1'b1;
				result.payload_byte = byte_in;
				result.last_payload = (pos_inc >= {1'b0, len_q});
				if (result.last_payload) begin
					phase_d = PH_TRAILER;
					pos_d   = '0;
				end else begin
					pos_d = pos_inc[POS_W-1:0];
				end
			end
			PH_TRAILER: begin
				if (pos_q == POS_W'(TRAILER_LEN - 1)) begin
					phase_d     = PH_MARKER;
					pos_d       = '0;
					len_d       = '0;
					len_hi_d    = 1'b0;
					has_result  = 1'b1;
					result.kind = KIND_DONE;
				end else begin
					pos_d = pos_inc[POS_W-1:0];
				end
			end
		endcase
	end

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> len_q != '0)
		else $error("payload phase with zero length");
	a_payload_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q < len_q)
		else $error("payload position past length");
	a_marker_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MARKER |-> pos_q < POS_W'(MARKER_LEN))
		else $error("marker position out of range");
	a_trailer_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TRAILER |-> pos_q < POS_W'(TRAILER_LEN))
		else $error("trailer position out of range");

endmodule

/* hw/rtl/mlfd_out_stage.sv */
// Result register of the deframer: holds one result transaction until the sink takes it.
// Depends on mlfd_pkg.
`timescale 1ns / 1ps

module mlfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mlfd_pkg::result_t result,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              free,
	output logic [1:0]        kind,
	output logic [7:0]        payload_byte,
	output logic              last_payload
);
	import mlfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = ~valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign last_payload = res_q.last_payload;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |-> !load)
		else $error("held result overwritten");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_stall |=> valid_q && $stable(res_q))
		else $error("stalled result changed");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_stall && !load |=> !valid_q)
		else $error("taken result still valid");

endmodule

/* hw/rtl/marker_length_frame_deframer.sv */
// Top level of the marker / length frame deframer: input register, parser, result register.
// Depends on mlfd_pkg, mlfd_parse and mlfd_out_stage.
`timescale 1ns / 1ps

// The deframer takes a byte stream made of frames: the 7-byte start marker "YFSTART",
// a 32-bit payload length sent least significant byte first, the payload, and a 5-byte
// trailer whose content is skipped. Each input transaction carries one byte and yields
// at most one result transaction: a payload byte (kind 0, with last_payload set on the
// final byte of the frame), frame complete (kind 1, on the last trailer byte), start
// marker mismatch (kind 2, the block keeps hunting and a stray 'Y' counts as a marker
// start) or length too large (kind 3, the block goes back to hunting). A frame with zero
// length gives no payload bytes, only frame complete. Lengths above max_payload_length,
// itself capped at 65519 so that a frame fits a 64 KiB buffer, are rejected.
// The block takes one byte every clock cycle while in_stall is low. A byte is held in an
// input register, the parser decides its result and next state in that cycle, and the
// result moves into the output register, where it is presented until the sink takes it.
// When the output register is full and stalled, a byte that makes a result waits in the
// input register and in_stall rises; bytes that make no result still pass. The limit
// register is written through cfg_valid / cfg_ready, which is always ready;
// write it only while no byte is in flight.

module marker_length_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_payload_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last_payload
);
	import mlfd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       has_result;
	logic       out_free;
	logic       advance;
	logic       in_accept;
	result_t    result;

	assign cfg_ready = 1'b1;

	// The held byte moves on when it makes no result or the result register has room.
	assign advance   = valid_s1 & (~has_result | out_free);
	assign in_stall  = valid_s1 & ~advance;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	mlfd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_data   (max_payload_length),
		.step       (advance),
		.byte_in    (rx_byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	mlfd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance & has_result),
		.result       (result),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.free         (out_free),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last_payload (last_payload)
	);

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> in_stall)
		else $error("input register overwritten");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> out_valid)
		else $error("result lost");
	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'h00 && !last_payload)
		else $error("non-payload result carries payload fields");

endmodule
